@@ rtl/sbs_pkg.sv @@
// shared constants, types and codes for the stripe bucket sort block
`timescale 1ns / 1ps
package sbs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_STRIPES = 32;

  localparam int COORD_W   = 32;
  localparam int TAG_W     = 8;
  localparam int SCNT_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int STRIPE_W = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
  localparam int SEC_W    = $clog2(MAX_STRIPES + 1);
  localparam int DIFF_W   = COORD_W + 1;
  localparam int NUM_W    = DIFF_W + SEC_W;
  localparam int KEY_W    = STRIPE_W + COORD_W + ADDR_W;
  localparam int DIV_STEP_W = $clog2(STRIPE_W + 1);

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [COORD_W-1:0] LOWER_Y_RST      = COORD_W'(0);
  localparam logic [COORD_W-1:0] UPPER_Y_RST      = COORD_W'(256000);
  localparam logic [SCNT_W-1:0]  STRIPE_COUNT_RST = SCNT_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_Y      = 2'd0,
    REG_UPPER_Y      = 2'd1,
    REG_STRIPE_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TAG_W-1:0]   tag;
    logic               clear;
  } cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [STRIPE_W-1:0] stripe;
    logic [SEC_W-1:0]    sections;
    logic                is_last;
    logic                is_empty;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0] lower_y;
    logic [COORD_W-1:0] upper_y;
    logic [SCNT_W-1:0]  stripe_count;
  } cfg_t;

endpackage

@@ rtl/sbs_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sbs_front.sv @@
// front end: accepts words, decodes them and queues commands for the engine
`timescale 1ns / 1ps
module sbs_front import sbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_operation,
  input  logic [COORD_W-1:0] in_center_x,
  input  logic [COORD_W-1:0] in_center_y,
  input  logic [TAG_W-1:0]   in_entry_tag,
  input  logic               in_clear_store,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_take
);

  cmd_t                q_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                push, pop;
  cmd_t                decoded;

  assign in_full   = (cnt_r == FQ_CNT_W'(FQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_take && cmd_valid;

  always_comb begin
    decoded.op    = op_t'(in_operation);
    decoded.x     = in_center_x;
    decoded.y     = in_center_y;
    decoded.tag   = in_entry_tag;
    decoded.clear = in_clear_store && (in_operation == OP_LOAD);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

@@ rtl/sbs_div.sv @@
// restoring divider, one quotient bit a cycle, for the stripe index
`timescale 1ns / 1ps
module sbs_div import sbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [COORD_W-1:0]  den,
  output logic                done,
  output logic [STRIPE_W-1:0] quo
);

  logic [NUM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      dsh_r;
  logic [STRIPE_W-1:0]   quo_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic                  busy_r, done_r;
  logic                  fits;

  assign fits = (rem_r >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DIV_STEP_W'(STRIPE_W);
      end else if (busy_r) begin
        step_r <= step_r - DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {{(NUM_W-COORD_W){1'b0}}, den} << (STRIPE_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[STRIPE_W-2:0], fits};
    end
  end

endmodule

@@ rtl/sbs_back.sv @@
// back end: stores entries, classifies them into stripes and emits in sorted order
`timescale 1ns / 1ps
module sbs_back import sbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SRD   = 9'b000000010,
    ST_SMUL  = 9'b000000100,
    ST_SDIV  = 9'b000001000,
    ST_SWR   = 9'b000010000,
    ST_EMIT  = 9'b000100000,
    ST_SCAN  = 9'b001000000,
    ST_SLAST = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_r, rdpos_r, idx_r;
  logic                sorted_r, empty_r;
  logic [STRIPE_W-1:0] st_r;
  logic                vld_d_r;
  logic [ADDR_W-1:0]   jd_r;
  logic [KEY_W-1:0]    best_key_r, last_key_r, cand_key;
  logic [TAG_W-1:0]    best_tag_r;
  logic                best_v_r;

  logic [SEC_W-1:0]    n_eff;
  logic [CNT_W-1:0]    cnt_eff;
  logic                load_we;
  logic [ADDR_W-1:0]   rd_addr;
  logic [COORD_W-1:0]  x_rd, y_rd;
  logic [TAG_W-1:0]    tag_rd;
  logic [STRIPE_W-1:0] stripe_rd;

  logic signed [DIFF_W-1:0] diff, den;
  logic                     at_top, special;
  logic [STRIPE_W-1:0]      special_st;
  logic [NUM_W-1:0]         num;
  logic                     div_start, div_done;
  logic [STRIPE_W-1:0]      div_quo;
  logic                     hit;
  logic [STRIPE_W-1:0]      s_cur, s_last;

  // effective stripe count: zero acts as one, large values saturate
  always_comb begin
    if (cfg.stripe_count == '0) begin
      n_eff = SEC_W'(1);
    end else if (int'(cfg.stripe_count) > MAX_STRIPES) begin
      n_eff = SEC_W'(MAX_STRIPES);
    end else begin
      n_eff = SEC_W'(cfg.stripe_count);
    end
  end

  assign cmd_take = (state_r == ST_IDLE) && cmd_valid;
  assign cnt_eff  = cmd.clear ? '0 : cnt_r;
  assign load_we  = cmd_take && (cmd.op == OP_LOAD) && (cnt_eff < CNT_W'(MAX_ENTRIES));
  assign rd_addr  = idx_r[ADDR_W-1:0];

  sbs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ENTRIES)) u_x_ram (
    .clk(clk), .wr_en(load_we), .wr_addr(cnt_eff[ADDR_W-1:0]), .wr_data(cmd.x),
    .rd_addr(rd_addr), .rd_data(x_rd)
  );

  sbs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ENTRIES)) u_y_ram (
    .clk(clk), .wr_en(load_we), .wr_addr(cnt_eff[ADDR_W-1:0]), .wr_data(cmd.y),
    .rd_addr(rd_addr), .rd_data(y_rd)
  );

  sbs_ram #(.WIDTH(TAG_W), .DEPTH(MAX_ENTRIES)) u_tag_ram (
    .clk(clk), .wr_en(load_we), .wr_addr(cnt_eff[ADDR_W-1:0]), .wr_data(cmd.tag),
    .rd_addr(rd_addr), .rd_data(tag_rd)
  );

  sbs_ram #(.WIDTH(STRIPE_W), .DEPTH(MAX_ENTRIES)) u_stripe_ram (
    .clk(clk), .wr_en(state_r == ST_SWR), .wr_addr(idx_r[ADDR_W-1:0]), .wr_data(st_r),
    .rd_addr(rd_addr), .rd_data(stripe_rd)
  );

  // stripe classification of the y word just read
  assign diff   = $signed({y_rd[COORD_W-1], y_rd}) -
                  $signed({cfg.lower_y[COORD_W-1], cfg.lower_y});
  assign den    = $signed({cfg.upper_y[COORD_W-1], cfg.upper_y}) -
                  $signed({cfg.lower_y[COORD_W-1], cfg.lower_y});
  assign at_top = $signed(y_rd) >= $signed(cfg.upper_y);
  assign num    = {{(NUM_W-COORD_W){1'b0}}, diff[COORD_W-1:0]} *
                  {{(NUM_W-SEC_W){1'b0}}, n_eff};

  always_comb begin
    special    = 1'b1;
    special_st = '0;
    if (den <= 0 || diff < 0) begin
      special_st = '0;
    end else if (at_top) begin
      special_st = STRIPE_W'(n_eff - SEC_W'(1));
    end else begin
      special = 1'b0;
    end
  end

  assign div_start = (state_r == ST_SMUL) && !special;

  sbs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num),
    .den(den[COORD_W-1:0]), .done(div_done), .quo(div_quo)
  );

  // sort key: stripe, then x with sign flipped, then load position for stability
  assign cand_key = {stripe_rd, ~x_rd[COORD_W-1], x_rd[COORD_W-2:0], jd_r};
  assign hit = (rdpos_r == '0 || cand_key > last_key_r) &&
               (!best_v_r || cand_key < best_key_r);

  assign s_cur  = best_key_r[KEY_W-1 -: STRIPE_W];
  assign s_last = last_key_r[KEY_W-1 -: STRIPE_W];

  always_comb begin
    res = '0;
    res.is_empty = empty_r;
    if (!empty_r) begin
      res.tag     = best_tag_r;
      res.stripe  = s_cur;
      res.is_last = (rdpos_r + CNT_W'(1)) == cnt_r;
      if (rdpos_r == '0) begin
        res.sections = SEC_W'(s_cur) + SEC_W'(1);
      end else if (s_cur != s_last) begin
        res.sections = SEC_W'(s_cur) - SEC_W'(s_last);
      end
    end
  end

  assign res_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == OP_EMIT) begin
          if (sorted_r || cnt_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD:  state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = special ? ST_SWR : ST_SDIV;
      ST_SDIV: begin
        if (div_done) begin
          state_nxt = ST_SWR;
        end
      end
      ST_SWR: begin
        if (idx_r + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_EMIT: state_nxt = (rdpos_r >= cnt_r) ? ST_OUT : ST_SCAN;
      ST_SCAN: begin
        if (idx_r + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_SLAST;
        end
      end
      ST_SLAST: state_nxt = ST_OUT;
      ST_OUT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rdpos_r  <= '0;
      sorted_r <= 1'b0;
      vld_d_r  <= 1'b0;
      best_v_r <= 1'b0;
      empty_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vld_d_r <= (state_r == ST_SCAN);
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_take && cmd.op == OP_LOAD) begin
            sorted_r <= 1'b0;
            rdpos_r  <= '0;
            cnt_r    <= load_we ? cnt_eff + CNT_W'(1) : cnt_eff;
          end else if (cmd_take) begin
            idx_r <= '0;
            if (cnt_r == '0) begin
              sorted_r <= 1'b1;
            end
          end
        end
        ST_SWR: begin
          if (idx_r + CNT_W'(1) == cnt_r) begin
            sorted_r <= 1'b1;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          empty_r  <= (rdpos_r >= cnt_r);
          idx_r    <= '0;
          best_v_r <= 1'b0;
        end
        ST_SCAN: begin
          if (idx_r + CNT_W'(1) != cnt_r) begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        ST_OUT: begin
          if (res_ready && !empty_r) begin
            rdpos_r <= rdpos_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (vld_d_r && hit) begin
        best_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SMUL) begin
      st_r <= special_st;
    end else if (state_r == ST_SDIV && div_done) begin
      st_r <= div_quo;
    end
    if (state_r == ST_SCAN) begin
      jd_r <= idx_r[ADDR_W-1:0];
    end
    if (vld_d_r && hit) begin
      best_key_r <= cand_key;
      best_tag_r <= tag_rd;
    end
    if (state_r == ST_OUT && res_ready && !empty_r) begin
      last_key_r <= best_key_r;
    end
  end

endmodule

@@ rtl/stripe_bucket_sort_top.sv @@
// top level: configuration registers, front and back ends, result register
// Entries are loaded with load words, which the engine takes from the two-word input
// queue, and read back sorted by stripe and then by x, one result per emit word.
// The first emit after any load classifies every stored entry with the stripe settings
// current at that moment: for each entry a ram read, a multiply, the five-step divider
// and a stripe ram write, skipping the divider for an entry outside the range. Each emit
// then scans all stored entries through the entry rams, one a cycle; an emit with nothing left
// skips the scan and returns an empty result. One result can wait in the output register
// without stalling the engine; a second finished result holds the engine until the first
// is popped, and the input queue then fills. Loads beyond 256 entries are dropped.
`timescale 1ns / 1ps
module stripe_bucket_sort_top import sbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_operation,
  input  logic [COORD_W-1:0]   in_center_x,
  input  logic [COORD_W-1:0]   in_center_y,
  input  logic [TAG_W-1:0]     in_entry_tag,
  input  logic                 in_clear_store,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [TAG_W-1:0]     out_tag,
  output logic [STRIPE_W-1:0]  out_stripe,
  output logic [SEC_W-1:0]     out_sections_here,
  output logic                 out_is_last,
  output logic                 out_is_empty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;
  logic res_valid, res_ready;
  res_t res, res_r;
  logic out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower_y      <= LOWER_Y_RST;
      cfg_r.upper_y      <= UPPER_Y_RST;
      cfg_r.stripe_count <= STRIPE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOWER_Y:      cfg_r.lower_y      <= cfg_data;
        REG_UPPER_Y:      cfg_r.upper_y      <= cfg_data;
        REG_STRIPE_COUNT: cfg_r.stripe_count <= cfg_data[SCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sbs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_entry_tag(in_entry_tag), .in_clear_store(in_clear_store),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  sbs_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  // single result register between engine and reader
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_tag           = res_r.tag;
  assign out_stripe        = res_r.stripe;
  assign out_sections_here = res_r.sections;
  assign out_is_last       = res_r.is_last;
  assign out_is_empty      = res_r.is_empty;

endmodule
